FILE: design/tgarle_pkg.sv
// ============================================================================
// tgarle_pkg: shared types and constants for the TGA RLE pixel decoder
// Item, result and command structs, config register indexes, pixel formats.
// ============================================================================
package tgarle_pkg;

  localparam int PIX_W      = 23;       // pixel counter / total width
  localparam int IDX_W      = 22;       // start index field width
  localparam int MAX_PIXELS = 4194304;  // total is clamped to this
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam int QDEPTH     = 2;        // front-to-back queue depth
  localparam int QPTR_W     = $clog2(QDEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RLE_MODE = 2'd0,
    REG_BPP      = 2'd1,
    REG_TOTAL    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FMT_16 = 3'b001,
    FMT_24 = 3'b010,
    FMT_32 = 3'b100
  } pix_fmt_t;

  typedef struct packed {
    logic             rle_mode;
    logic [2:0]       bytes_per_pixel;
    logic [PIX_W-1:0] total_pixels;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } src_item_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [7:0]       run_length;
    logic [IDX_W-1:0] start_index;
    logic             image_done;
  } pix_item_t;

  // Pixel command: raw source bytes plus placement, colour not yet converted
  typedef struct packed {
    pix_fmt_t         fmt;
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [7:0]       last;
    logic [7:0]       run_length;
    logic [IDX_W-1:0] start_index;
    logic             image_done;
  } cmd_t;

endpackage

FILE: design/tgarle_front.sv
// ============================================================================
// tgarle_front: byte parser
// Assembles source pixels, decodes packet headers, tracks the pixel index,
// clips runs and issues one pixel command per completed pixel.
// ============================================================================
module tgarle_front import tgarle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      accept,
  input  src_item_t item,
  output logic      cmd_valid,
  output cmd_t      cmd
);

  logic [1:0]       byte_pos, byte_pos_next;
  logic [7:0]       pixel_bytes [3];
  logic             expect_header, expect_header_next;
  logic             run_packet, run_packet_next;
  logic [6:0]       literal_left, literal_left_next;
  logic [6:0]       repeat_count, repeat_count_next;
  logic [PIX_W-1:0] pixel_index, pixel_index_next;
  logic             finished, finished_next;

  // working copies after an optional frame clear
  logic [1:0]       bp_w;
  logic             eh_w, rp_w, fin_w;
  logic [6:0]       ll_w, rc_w;
  logic [PIX_W-1:0] pi_w;

  logic [2:0]       bpp_eff;
  pix_fmt_t         fmt;
  logic [PIX_W-1:0] total_eff;
  logic [PIX_W-1:0] left;
  logic [7:0]       len_raw, len;
  logic [PIX_W-1:0] pi_sum;
  logic             pb_we;

  always_comb begin
    if (cfg.bytes_per_pixel <= 3'd2) begin
      bpp_eff = 3'd2;
      fmt     = FMT_16;
    end else if (cfg.bytes_per_pixel >= 3'd4) begin
      bpp_eff = 3'd4;
      fmt     = FMT_32;
    end else begin
      bpp_eff = 3'd3;
      fmt     = FMT_24;
    end
  end

  assign total_eff = (cfg.total_pixels > PIX_W'(MAX_PIXELS)) ? PIX_W'(MAX_PIXELS)
                                                             : cfg.total_pixels;

  assign bp_w  = item.frame_start ? 2'd0 : byte_pos;
  assign eh_w  = item.frame_start ? 1'b1 : expect_header;
  assign rp_w  = item.frame_start ? 1'b0 : run_packet;
  assign ll_w  = item.frame_start ? 7'd0 : literal_left;
  assign rc_w  = item.frame_start ? 7'd0 : repeat_count;
  assign pi_w  = item.frame_start ? '0 : pixel_index;
  assign fin_w = item.frame_start ? 1'b0 : finished;

  // run length before and after clipping to the pixels left
  assign len_raw = (cfg.rle_mode && rp_w) ? ({1'b0, rc_w} + 8'd1) : 8'd1;
  assign left    = total_eff - pi_w;
  assign len     = (PIX_W'(len_raw) > left) ? left[7:0] : len_raw;
  assign pi_sum  = pi_w + PIX_W'(len);

  always_comb begin
    byte_pos_next      = byte_pos;
    expect_header_next = expect_header;
    run_packet_next    = run_packet;
    literal_left_next  = literal_left;
    repeat_count_next  = repeat_count;
    pixel_index_next   = pixel_index;
    finished_next      = finished;
    pb_we              = 1'b0;
    cmd_valid          = 1'b0;
    cmd.fmt            = fmt;
    cmd.b0             = pixel_bytes[0];
    cmd.b1             = pixel_bytes[1];
    cmd.b2             = pixel_bytes[2];
    cmd.last           = item.data_byte;
    cmd.run_length     = len;
    cmd.start_index    = pi_w[IDX_W-1:0];
    cmd.image_done     = (pi_sum >= total_eff);
    if (accept) begin
      byte_pos_next      = bp_w;
      expect_header_next = eh_w;
      run_packet_next    = rp_w;
      literal_left_next  = ll_w;
      repeat_count_next  = rc_w;
      pixel_index_next   = pi_w;
      finished_next      = fin_w;
      if (fin_w || (pi_w >= total_eff)) begin
        finished_next = 1'b1;
      end else if (cfg.rle_mode && eh_w && (bp_w == 2'd0)) begin
        // packet header: kind and count, no pixel
        run_packet_next    = item.data_byte[7];
        repeat_count_next  = item.data_byte[6:0];
        literal_left_next  = item.data_byte[6:0];
        expect_header_next = 1'b0;
      end else if ({1'b0, bp_w} < (bpp_eff - 3'd1)) begin
        pb_we         = 1'b1;
        byte_pos_next = bp_w + 2'd1;
      end else begin
        byte_pos_next = 2'd0;
        cmd_valid     = 1'b1;
        if (cfg.rle_mode) begin
          if (rp_w || (ll_w == 7'd0)) begin
            expect_header_next = 1'b1;
          end else begin
            literal_left_next = ll_w - 7'd1;
          end
        end
        pixel_index_next = pi_sum;
        finished_next    = (pi_sum >= total_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= 2'd0;
      expect_header <= 1'b1;
      run_packet    <= 1'b0;
      literal_left  <= 7'd0;
      repeat_count  <= 7'd0;
      pixel_index   <= '0;
      finished      <= 1'b0;
    end else begin
      byte_pos      <= byte_pos_next;
      expect_header <= expect_header_next;
      run_packet    <= run_packet_next;
      literal_left  <= literal_left_next;
      repeat_count  <= repeat_count_next;
      pixel_index   <= pixel_index_next;
      finished      <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pb_we) begin
      pixel_bytes[bp_w] <= item.data_byte;
    end
  end

endmodule

FILE: design/tgarle_queue.sv
// ============================================================================
// tgarle_queue: command queue
// Short FIFO of pixel commands between the parser and the colour stage.
// ============================================================================
module tgarle_queue import tgarle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_cmd
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count, count_next;

  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr_en && !rd_en) begin
      count_next = count + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

endmodule

FILE: design/tgarle_back.sv
// ============================================================================
// tgarle_back: colour stage
// Converts queued pixel commands to 8-bit RGBA and holds the result register.
// ============================================================================
module tgarle_back import tgarle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      take,
  input  logic      pop,
  output logic      empty,
  output pix_item_t pixel
);

  localparam logic [7:0] R5_MASK    = 8'h7c;
  localparam logic [7:0] G_HI_MASK  = 8'h03;
  localparam logic [7:0] G_LO_MASK  = 8'he0;
  localparam logic [7:0] B5_MASK    = 8'h1f;
  localparam logic [7:0] ALPHA_BIT  = 8'h80;
  localparam logic [7:0] OPAQUE     = 8'hff;

  logic      out_valid;
  logic      pop_ok;
  pix_item_t conv;

  assign empty  = !out_valid;
  assign pop_ok = pop && out_valid;
  assign take   = cmd_valid && (!out_valid || pop_ok);

  always_comb begin
    conv.run_length  = cmd.run_length;
    conv.start_index = cmd.start_index;
    conv.image_done  = cmd.image_done;
    unique case (cmd.fmt)
      FMT_32: begin
        conv.red   = cmd.b2;
        conv.green = cmd.b1;
        conv.blue  = cmd.b0;
        conv.alpha = cmd.last;
      end
      FMT_24: begin
        conv.red   = cmd.last;
        conv.green = cmd.b1;
        conv.blue  = cmd.b0;
        conv.alpha = OPAQUE;
      end
      FMT_16: begin
        // X1R5G5B5, low byte first
        conv.red   = (cmd.last & R5_MASK) << 1;
        conv.green = ((cmd.last & G_HI_MASK) << 6) | ((cmd.b0 & G_LO_MASK) >> 2);
        conv.blue  = (cmd.b0 & B5_MASK) << 3;
        conv.alpha = cmd.last & ALPHA_BIT;
      end
      default: begin
        conv.red   = 8'd0;
        conv.green = 8'd0;
        conv.blue  = 8'd0;
        conv.alpha = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pop_ok) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pixel <= conv;
    end
  end

endmodule

FILE: design/tga_rle_pixel_decoder.sv
// ============================================================================
// tga_rle_pixel_decoder: TGA truecolour pixel decoder (raw and RLE)
// Takes image data bytes after the header and produces RGBA runs.
// ============================================================================
//
//  channel   handshake                payload              direction
//  --------  -----------------------  -------------------  ---------
//  source    push / full              src_item_t (byte)    in
//  result    empty / pop              pix_item_t (run)     out
//  config    cfg_valid / cfg_ready    cfg_index, cfg_data  in
//
// One byte a cycle while full is low; the parser settles all state for a byte
// at its accepting edge, so bytes may follow back to back. A pixel's command
// passes from the parser through the 2-entry queue into the result reg.
// full rises only once the queue holds two commands, i.e. after pop has
// stalled. Synchronous reset clears counters, queue and result valid; config
// returns to raw mode, 4 bytes per pixel, 1 pixel. cfg_ready is always high.
//
module tga_rle_pixel_decoder import tgarle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // byte requests
  input  logic                  push,
  output logic                  full,
  input  src_item_t             source,
  // result requests
  output logic                  empty,
  input  logic                  pop,
  output pix_item_t             pixel,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_take;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rle_mode        <= 1'b0;
      cfg.bytes_per_pixel <= 3'd4;
      cfg.total_pixels    <= PIX_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RLE_MODE: cfg.rle_mode        <= cfg_data[0];
        REG_BPP:      cfg.bytes_per_pixel <= cfg_data[2:0];
        REG_TOTAL:    cfg.total_pixels    <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // parser: header decode, byte assembly, index and clipping
  tgarle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .item      (source),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // decouples parser from the colour stage
  tgarle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_valid),
    .wr_cmd   (cmd),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  // colour conversion and result register
  tgarle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .take      (q_take),
    .pop       (pop),
    .empty     (empty),
    .pixel     (pixel)
  );

  // a pixel command is only ever issued for an accepted byte
  a_cmd_from_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (push && !full))
    else $error("pixel command without an accepted byte");

  // a shown result always covers one to 128 pixels
  a_run_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((pixel.run_length != 8'd0) && (pixel.run_length <= 8'd128)))
    else $error("result run length out of range");

  // nothing is shown straight after reset
  a_empty_after_rst: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result shown after reset");

endmodule

FILE: sim/tb_tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_tga_rle_pixel_decoder: self-checking bench for the TGA pixel decoder
// Streams raw and RLE image bytes under many register settings, predicts each
// RGBA run in a behavioural decoder and checks the results in order.
// ============================================================================
module tb_tga_rle_pixel_decoder;
  import tgarle_pkg::*;

  localparam int QUIET_LIMIT = 1000;  // cycles with no request moving at all
  localparam int RANDOM_BYTES = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // byte requests
  logic      push = 1'b0;
  logic      full;
  src_item_t source = '0;
  // result requests
  logic      empty;
  logic      pop = 1'b0;
  pix_item_t pixel;
  // register writes
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_RLE_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  tga_rle_pixel_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .source    (source),
    .empty     (empty),
    .pop       (pop),
    .pixel     (pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  src_item_t byte_queue[$];       // bytes still to be offered
  pix_item_t expected_pixels[$];  // predicted runs not yet popped

  bit src_took;        // byte request accepted at the last rising edge
  bit calm;            // final stretch: no idling on either side
  int idle_odds = 4;   // 1-in-N chance of an idle burst after a request; 0 = none
  bit fs_pending;      // next queued byte carries frame_start
  int push_gap, pop_gap;
  int errors, bytes_taken, runs_checked, settings, quiet;

  // --------------------------------------------------------------------------
  // Behavioural decoder: register copies plus parser state
  // --------------------------------------------------------------------------
  logic        m_rle;
  logic [2:0]  m_bpp;
  logic [22:0] m_total;

  logic [1:0]  byte_pos;
  logic [7:0]  pix_bytes[3];
  logic        hdr_wait;    // next byte at pixel boundary is a packet header
  logic        run_pkt;
  logic [6:0]  lit_left;
  logic [6:0]  rep_cnt;
  logic [22:0] pix_idx;
  logic        img_done;

  // 0/1 behave as 16-bit, 5..7 as 32-bit
  function automatic int eff_bpp(input logic [2:0] raw);
    if (raw <= 3'd2) return 2;
    if (raw >= 3'd4) return 4;
    return 3;
  endfunction

  function automatic void clear_decoder();
    byte_pos = '0;
    hdr_wait = 1'b1;
    run_pkt  = 1'b0;
    lit_left = '0;
    rep_cnt  = '0;
    pix_idx  = '0;
    img_done = 1'b0;
  endfunction

  // Returns 1 when the byte completes a pixel and fills px with the run.
  function automatic bit decode_byte(input src_item_t it, output pix_item_t px);
    int          bpp;
    logic [22:0] tot, len, left;
    logic [7:0]  b, lo;
    bpp = eff_bpp(m_bpp);
    tot = (m_total > MAX_PIXELS) ? 23'(MAX_PIXELS) : m_total;
    b   = it.data_byte;
    px  = '0;
    if (it.frame_start) clear_decoder();
    // image already complete (or empty): byte is dropped
    if (img_done || pix_idx >= tot) begin
      img_done = 1'b1;
      return 1'b0;
    end
    if (m_rle && hdr_wait && byte_pos == 2'd0) begin
      run_pkt  = b[7];
      rep_cnt  = b[6:0];
      lit_left = b[6:0];
      hdr_wait = 1'b0;
      return 1'b0;
    end
    if (int'(byte_pos) < bpp - 1) begin
      pix_bytes[byte_pos] = b;
      byte_pos = byte_pos + 2'd1;
      return 1'b0;
    end
    byte_pos = '0;

    // BGRA / BGR reorder, X1R5G5B5 expand with zero fill
    case (bpp)
      4: begin
        px.red = pix_bytes[2]; px.green = pix_bytes[1];
        px.blue = pix_bytes[0]; px.alpha = b;
      end
      3: begin
        px.red = b; px.green = pix_bytes[1];
        px.blue = pix_bytes[0]; px.alpha = 8'hff;
      end
      default: begin
        lo = pix_bytes[0];
        px.red   = {b[6:2], 3'b000};
        px.green = {b[1:0], lo[7:5], 3'b000};
        px.blue  = {lo[4:0], 3'b000};
        px.alpha = {b[7], 7'b0};
      end
    endcase

    len = 23'd1;
    if (m_rle) begin
      if (run_pkt) begin
        len = 23'(rep_cnt) + 23'd1;
        hdr_wait = 1'b1;
      end else if (lit_left == '0) begin
        hdr_wait = 1'b1;
      end else begin
        lit_left = lit_left - 7'd1;
      end
    end

    // clip a run that would overrun the image
    left = tot - pix_idx;
    if (len > left) len = left;

    px.run_length  = len[7:0];
    px.start_index = pix_idx[IDX_W-1:0];
    pix_idx = pix_idx + len;
    if (pix_idx >= tot) img_done = 1'b1;
    px.image_done = img_done;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0d ns: %s mismatch, expected %0d (0x%0h) got %0d (0x%0h)",
               $time, name, want, want, got, got);
      errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pix_item_t want;
    pix_item_t pred;
    if (rst) begin
      src_took = 1'b0;
      m_rle = 1'b0;
      m_bpp = 3'd4;
      m_total = 23'd1;
      foreach (pix_bytes[i]) pix_bytes[i] = '0;
      clear_decoder();
      quiet = 0;
    end else begin
      src_took = push && !full;
      if (src_took) begin
        bytes_taken++;
        if (decode_byte(source, pred)) expected_pixels.push_back(pred);
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RLE_MODE: m_rle   = cfg_data[0];
          REG_BPP:      m_bpp   = cfg_data[2:0];
          REG_TOTAL:    m_total = cfg_data[22:0];
          default: ;
        endcase
      end

      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $display("%0d ns: unexpected result, expected none, got %h", $time, pixel);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red",         want.red,         pixel.red);
          check_field("green",       want.green,       pixel.green);
          check_field("blue",        want.blue,        pixel.blue);
          check_field("alpha",       want.alpha,       pixel.alpha);
          check_field("run_length",  want.run_length,  pixel.run_length);
          check_field("start_index", want.start_index, pixel.start_index);
          check_field("image_done",  want.image_done,  pixel.image_done);
          runs_checked++;
        end
      end

      // watchdog: any request moving on any channel counts as progress
      if (src_took || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0d ns: no request moved for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte driver: offers queued bytes, holds a request until it is taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      push_gap = 0;
    end else if (!push || src_took) begin
      if (push_gap > 0) begin
        push <= 1'b0;
        push_gap--;
      end else if (byte_queue.size() > 0) begin
        source <= byte_queue.pop_front();
        push   <= 1'b1;
        if (!calm && idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0)
          push_gap = $urandom_range(1, 19);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side: pop with random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_gap = 0;
    end else if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap--;
    end else begin
      pop <= 1'b1;
      if (!calm && idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0)
        pop_gap = $urandom_range(1, 19);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    src_item_t it;
    it.data_byte   = b;
    it.frame_start = fs_pending;
    fs_pending = 1'b0;
    byte_queue.push_back(it);
  endtask

  task automatic queue_pixel(input int bpp);
    for (int k = 0; k < bpp; k++) queue_byte(8'($urandom_range(0, 255)));
  endtask

  // Wait until the block is idle: nothing queued, nothing offered, nothing
  // outstanding, then give a trailing header byte time to settle.
  task automatic drain();
    do @(posedge clk);
    while (byte_queue.size() != 0 || push || expected_pixels.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Write all three registers back to back; valid stays high between writes.
  task automatic configure(input logic rle, input logic [2:0] bpp,
                           input logic [22:0] total);
    cfg_reg_t            idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    idx = '{REG_RLE_MODE, REG_BPP, REG_TOTAL};
    val = '{CFG_DATA_W'(rle), CFG_DATA_W'(bpp), total};
    for (int k = 0; k < 3; k++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // Mostly well-formed packets with random content, some loose noise bytes
  task automatic fill_random(input int n, input logic rle, input int bpp);
    int         left;
    logic [6:0] cnt;
    logic       runp;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 7) == 0) fs_pending = 1'b1;
        queue_byte(8'($urandom_range(0, 255)));
        left--;
      end else if (rle) begin
        cnt  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 5));
        runp = 1'($urandom_range(0, 1));
        queue_byte({runp, cnt});
        left--;
        // long literals get cut short by the phase budget
        for (int k = 0; k < (runp ? 1 : int'(cnt) + 1) && left > 0; k++) begin
          queue_pixel(bpp);
          left -= bpp;
        end
      end else begin
        queue_pixel(bpp);
        left -= bpp;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic        rle;
    logic [2:0]  bpp;
    logic [22:0] total;
    int          n, queued;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // raw 32-bit: all-zero and all-one pixels, second one completes the image
    configure(1'b0, 3'd4, 23'd2);
    fs_pending = 1'b1;
    repeat (4) queue_byte(8'h00);
    repeat (4) queue_byte(8'hff);
    drain();

    // RLE 16-bit (size 1 acts as 2): run of 2, literal of 2, then a run of 128
    // clipped to the last pixel; a further byte is dropped as the image is done
    configure(1'b1, 3'd1, 23'd5);
    fs_pending = 1'b1;
    queue_byte(8'h81); queue_byte(8'hff); queue_byte(8'hff);
    queue_byte(8'h01); queue_byte(8'h00); queue_byte(8'h00);
    queue_byte(8'he0); queue_byte(8'h7f);
    queue_byte(8'hff); queue_byte(8'h12); queue_byte(8'h34);
    queue_byte(8'haa);
    drain();

    // empty image: nothing is ever produced
    configure(1'b1, 3'd3, 23'd0);
    fs_pending = 1'b1;
    queue_byte(8'h5a);
    drain();

    // oversized total clamps; size 7 acts as 4
    configure(1'b0, 3'd7, 23'h7fffff);
    fs_pending = 1'b1;
    queue_byte(8'h11); queue_byte(8'h22); queue_byte(8'h33); queue_byte(8'h44);
    drain();

    // settings change mid-stream: counters carry on into 24-bit raw
    configure(1'b0, 3'd3, 23'd2);
    queue_byte(8'h80); queue_byte(8'h7f); queue_byte(8'h01);
    drain();

    // random phases, each under a fresh random setting
    queued = 0;
    while (queued < RANDOM_BYTES) begin
      rle = 1'($urandom_range(0, 1));
      bpp = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       total = 23'd0;
        1:       total = 23'($urandom_range(0, 23'h7fffff));
        2:       total = 23'h7fffff;
        3:       total = 23'd1;
        default: total = 23'($urandom_range(1, 40));
      endcase
      n = $urandom_range(15, 50);
      // last stretch runs flat out on both sides
      if (RANDOM_BYTES - queued <= 60) calm = 1'b1;
      case ($urandom_range(0, 2))
        0:       idle_odds = 0;
        1:       idle_odds = 3;
        default: idle_odds = 12;
      endcase
      configure(rle, bpp, total);
      fs_pending = ($urandom_range(0, 9) != 0);
      fill_random(n, rle, eff_bpp(bpp));
      queued += n;
      drain();
    end

    $display("Covered %0d bytes over %0d settings: raw and RLE, 16/24/32-bit pixels,",
             bytes_taken, settings);
    $display("clipped runs, empty and oversized images, restarts; %0d runs checked.",
             runs_checked);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
